// ===== hdl/qse_pkg.sv =====
// Package for the quicksort engine: controller state type.
// No dependencies; imported by quicksort_engine.
package qse_pkg;

   typedef enum logic [4:0] {
      ST_LOAD,
      ST_PIV_RD,
      ST_POP,
      ST_POP_WAIT,
      ST_PIV_WAIT,
      ST_L_RD,
      ST_L_CMP,
      ST_R_RD,
      ST_R_CMP,
      ST_CHECK,
      ST_SWAP_A,
      ST_SWAP_B,
      ST_FIX_A,
      ST_FIX_B,
      ST_PUSH_HI,
      ST_PUSH_LO,
      ST_OUT_RD,
      ST_OUT_WAIT,
      ST_OUT_HOLD
   } qse_state_type;

endpackage

// ===== hdl/quicksort_engine.sv =====
// Quicksort engine: loads a batch of signed values, sorts them in place by
// quicksort with first-element pivot and an explicit range stack, emits them.
// Depends on qse_pkg and qse_ram.
// Load: one transaction per cycle. Sort: each read of the sort store has
// a read state and a compare state (about 2*N*log2(N) reads on average,
// N*N at worst), plus per-partition states for stack pop, pivot fetch,
// swaps, pushes. Emit: a result is read from the store, held until taken.
// Synchronous active-high reset clears the controller, fill count, stack
// pointer, overflow flag and result valid; the memories are not cleared.
module quicksort_engine #(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [DATA_WIDTH-1:0] req_sample,
   input  logic                         req_final_item,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [DATA_WIDTH-1:0] rsp_sorted_value,
   output logic                         rsp_final_result,
   output logic                         rsp_overflow
);

   import qse_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = IDX_W + 1;
   localparam int STK_W = 2 * IDX_W;

   qse_state_type state_ff, state_in;

   logic [CNT_W-1:0]      fill_ff, fill_in;
   logic                  dropped_ff, dropped_in;
   logic [CNT_W-1:0]      sp_ff, sp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]      lo_ff, lo_in;
   logic [IDX_W-1:0]      hi_ff, hi_in;
   logic [CNT_W-1:0]      l_ff, l_in;
   logic [IDX_W-1:0]      r_ff, r_in;
   logic [CNT_W-1:0]      k_ff, k_in;
   logic [DATA_WIDTH-1:0] pv_ff, pv_in;
   logic [DATA_WIDTH-1:0] lv_ff, lv_in;
   logic [DATA_WIDTH-1:0] rv_ff, rv_in;
   logic [DATA_WIDTH-1:0] out_val_ff, out_val_in;
   logic                  out_last_ff, out_last_in;
   logic                  out_ovf_ff, out_ovf_in;

   logic                  st_we;
   logic [IDX_W-1:0]      st_waddr, st_raddr;
   logic [DATA_WIDTH-1:0] st_wdata, st_rdata;
   logic                  sk_we;
   logic [IDX_W-1:0]      sk_waddr, sk_raddr;
   logic [STK_W-1:0]      sk_wdata, sk_rdata;

   logic                  req_fire, rsp_fire;
   logic [CNT_W-1:0]      n_load;
   logic                  rd_le_pv;
   logic [CNT_W-1:0]      lo_ext, hi_ext, r_ext;

   qse_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_waddr),
      .wr_data (st_wdata),
      .rd_addr (st_raddr),
      .rd_data (st_rdata)
   );

   qse_ram #(.WIDTH(STK_W), .DEPTH(DEPTH)) u_stack (
      .clock   (clock),
      .wr_en   (sk_we),
      .wr_addr (sk_waddr),
      .wr_data (sk_wdata),
      .rd_addr (sk_raddr),
      .rd_data (sk_rdata)
   );

   assign req_ready        = (state_ff == ST_LOAD);
   assign req_fire         = req_valid && req_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_fire         = rsp_valid_ff && rsp_ready;
   assign rsp_sorted_value = $signed(out_val_ff);
   assign rsp_final_result = out_last_ff;
   assign rsp_overflow     = out_ovf_ff;

   assign n_load   = (fill_ff < CNT_W'(DEPTH)) ? fill_ff + CNT_W'(1) : fill_ff;
   assign rd_le_pv = ($signed(st_rdata) <= $signed(pv_ff));
   assign lo_ext   = {1'b0, lo_ff};
   assign hi_ext   = {1'b0, hi_ff};
   assign r_ext    = {1'b0, r_ff};

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_fire && req_final_item) begin
               state_in = (n_load >= CNT_W'(2)) ? ST_PIV_RD : ST_OUT_RD;
            end
         end
         ST_PIV_RD:   state_in = ST_PIV_WAIT;
         ST_POP:      state_in = (sp_ff == '0) ? ST_OUT_RD : ST_POP_WAIT;
         ST_POP_WAIT: state_in = ST_PIV_WAIT;
         ST_PIV_WAIT: state_in = ST_L_RD;
         ST_L_RD:     state_in = (l_ff > hi_ext) ? ST_R_RD : ST_L_CMP;
         ST_L_CMP:    state_in = rd_le_pv ? ST_L_RD : ST_R_RD;
         ST_R_RD:     state_in = (r_ff > lo_ff) ? ST_R_CMP : ST_CHECK;
         ST_R_CMP:    state_in = rd_le_pv ? ST_CHECK : ST_R_RD;
         ST_CHECK: begin
            if (l_ff > r_ext) begin
               state_in = (r_ff == lo_ff) ? ST_PUSH_HI : ST_FIX_A;
            end else begin
               state_in = ST_SWAP_A;
            end
         end
         ST_SWAP_A:   state_in = ST_SWAP_B;
         ST_SWAP_B:   state_in = ST_L_RD;
         ST_FIX_A:    state_in = ST_FIX_B;
         ST_FIX_B:    state_in = ST_PUSH_HI;
         ST_PUSH_HI:  state_in = ST_PUSH_LO;
         ST_PUSH_LO:  state_in = ST_POP;
         ST_OUT_RD:   state_in = ST_OUT_WAIT;
         ST_OUT_WAIT: state_in = ST_OUT_HOLD;
         ST_OUT_HOLD: begin
            if (rsp_fire) begin
               state_in = out_last_ff ? ST_LOAD : ST_OUT_RD;
            end
         end
         default:     state_in = ST_LOAD;
      endcase
   end

   // Datapath and memory controls
   always_comb begin
      fill_in      = fill_ff;
      dropped_in   = dropped_ff;
      sp_in        = sp_ff;
      rsp_valid_in = rsp_valid_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      l_in         = l_ff;
      r_in         = r_ff;
      k_in         = k_ff;
      pv_in        = pv_ff;
      lv_in        = lv_ff;
      rv_in        = rv_ff;
      out_val_in   = out_val_ff;
      out_last_in  = out_last_ff;
      out_ovf_in   = out_ovf_ff;
      st_we        = 1'b0;
      st_waddr     = '0;
      st_wdata     = '0;
      st_raddr     = '0;
      sk_we        = 1'b0;
      sk_waddr     = sp_ff[IDX_W-1:0];
      sk_wdata     = '0;
      sk_raddr     = '0;
      case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               if (fill_ff < CNT_W'(DEPTH)) begin
                  st_we    = 1'b1;
                  st_waddr = fill_ff[IDX_W-1:0];
                  st_wdata = req_sample;
                  fill_in  = n_load;
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_final_item) begin
                  sp_in = '0;
                  lo_in = '0;
                  hi_in = IDX_W'(n_load - CNT_W'(1));
                  k_in  = '0;
               end
            end
         end
         ST_PIV_RD: begin
            st_raddr = lo_ff;
         end
         ST_POP: begin
            if (sp_ff != '0) begin
               sp_in    = sp_ff - CNT_W'(1);
               sk_raddr = sp_in[IDX_W-1:0];
            end else begin
               k_in = '0;
            end
         end
         ST_POP_WAIT: begin
            lo_in    = sk_rdata[STK_W-1:IDX_W];
            hi_in    = sk_rdata[IDX_W-1:0];
            st_raddr = sk_rdata[STK_W-1:IDX_W];
         end
         ST_PIV_WAIT: begin
            pv_in = st_rdata;
            l_in  = lo_ext + CNT_W'(1);
            r_in  = hi_ff;
         end
         ST_L_RD: begin
            st_raddr = l_ff[IDX_W-1:0];
         end
         ST_L_CMP: begin
            if (rd_le_pv) begin
               l_in = l_ff + CNT_W'(1);
            end else begin
               lv_in = st_rdata;
            end
         end
         ST_R_RD: begin
            st_raddr = r_ff;
         end
         ST_R_CMP: begin
            if (rd_le_pv) begin
               rv_in = st_rdata;
            end else begin
               r_in = r_ff - IDX_W'(1);
            end
         end
         ST_SWAP_A: begin
            st_we    = 1'b1;
            st_waddr = l_ff[IDX_W-1:0];
            st_wdata = rv_ff;
         end
         ST_SWAP_B: begin
            st_we    = 1'b1;
            st_waddr = r_ff;
            st_wdata = lv_ff;
         end
         ST_FIX_A: begin
            st_we    = 1'b1;
            st_waddr = lo_ff;
            st_wdata = rv_ff;
         end
         ST_FIX_B: begin
            st_we    = 1'b1;
            st_waddr = r_ff;
            st_wdata = pv_ff;
         end
         ST_PUSH_HI: begin
            // right part, pivot slot is r
            if (r_ext + CNT_W'(1) < hi_ext) begin
               sk_we    = 1'b1;
               sk_wdata = {r_ff + IDX_W'(1), hi_ff};
               sp_in    = sp_ff + CNT_W'(1);
            end
         end
         ST_PUSH_LO: begin
            if (r_ext > lo_ext + CNT_W'(1)) begin
               sk_we    = 1'b1;
               sk_wdata = {lo_ff, r_ff - IDX_W'(1)};
               sp_in    = sp_ff + CNT_W'(1);
            end
         end
         ST_OUT_RD: begin
            st_raddr = k_ff[IDX_W-1:0];
         end
         ST_OUT_WAIT: begin
            out_val_in   = st_rdata;
            out_last_in  = (k_ff + CNT_W'(1) == fill_ff);
            out_ovf_in   = dropped_ff;
            rsp_valid_in = 1'b1;
         end
         ST_OUT_HOLD: begin
            if (rsp_fire) begin
               rsp_valid_in = 1'b0;
               k_in         = k_ff + CNT_W'(1);
               if (out_last_ff) begin
                  fill_in    = '0;
                  dropped_in = 1'b0;
               end
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         fill_ff      <= '0;
         dropped_ff   <= 1'b0;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         dropped_ff   <= dropped_in;
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      l_ff        <= l_in;
      r_ff        <= r_in;
      k_ff        <= k_in;
      pv_ff       <= pv_in;
      lv_ff       <= lv_in;
      rv_ff       <= rv_in;
      out_val_ff  <= out_val_in;
      out_last_ff <= out_last_in;
      out_ovf_ff  <= out_ovf_in;
   end

   a_rsp_only_in_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_OUT_HOLD))
      else $error("result valid outside output hold");

   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= CNT_W'(DEPTH / 2))
      else $error("range stack holds more than DEPTH/2 ranges");

   a_left_cursor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_L_CMP) |-> (l_ff <= hi_ext) && (l_ff > lo_ext))
      else $error("left cursor compared outside its range");

   a_right_cursor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_R_CMP) |-> (r_ff > lo_ff) && (r_ff <= hi_ff))
      else $error("right cursor compared outside its range");

   a_batch_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && out_last_ff) |=> (fill_ff == '0) && !dropped_ff)
      else $error("batch state not cleared after last result");

endmodule

// ===== hdl/qse_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used for the sort store and the range stack.
module qse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== tb/tb_top.sv =====
// Testbench for quicksort_engine: sends batches of signed values and checks that each batch
// comes back sorted ascending, with the last-result and overflow flags set correctly.
// Depends on quicksort_engine (and its package and memory); this file is self-contained.
`timescale 1ns / 1ps

module tb_top;

   localparam int DEPTH       = 64;
   localparam int DATA_WIDTH  = 32;
   localparam int RANDOM_ITEMS = 320;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int REPORT_MAX  = 10;

   localparam logic signed [DATA_WIDTH-1:0] VAL_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [DATA_WIDTH-1:0] VAL_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   typedef enum int {
      FILL_RANDOM,
      FILL_ASCENDING,
      FILL_DESCENDING,
      FILL_EQUAL,
      FILL_NARROW,
      FILL_EXTREMES
   } fill_kind_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] value;
      logic                         last;
      logic                         ovf;
   } sorted_entry_type;

   // Collects one batch, sorts it on the closing transaction and queues the sorted results.
   class batch_sort_board;
      int                           cap;
      logic signed [DATA_WIDTH-1:0] held[$];
      logic                         dropped;
      sorted_entry_type             sorted_due[$];
      int                           errors;

      function new(int depth);
         cap     = depth;
         dropped = 1'b0;
         errors  = 0;
      endfunction

      function void take_sample(logic signed [DATA_WIDTH-1:0] value, logic closing);
         logic signed [DATA_WIDTH-1:0] key;
         sorted_entry_type             entry;
         int                           i;
         int                           j;
         if (held.size() < cap)
            held.push_back(value);
         else
            dropped = 1'b1;
         if (closing) begin
            for (i = 1; i < held.size(); i++) begin
               key = held[i];
               j = i - 1;
               while (j >= 0 && held[j] > key) begin
                  held[j+1] = held[j];
                  j--;
               end
               held[j+1] = key;
            end
            for (i = 0; i < held.size(); i++) begin
               entry.value = held[i];
               entry.last  = (i == held.size() - 1);
               entry.ovf   = dropped;
               sorted_due.push_back(entry);
            end
            held.delete();
            dropped = 1'b0;
         end
      endfunction

      function void check_sorted(logic signed [DATA_WIDTH-1:0] value, logic last, logic ovf);
         sorted_entry_type want;
         if (sorted_due.size() == 0) begin
            errors++;
            if (errors <= REPORT_MAX)
               $display("unexpected result: value %0d last %0b overflow %0b", value, last, ovf);
         end else begin
            want = sorted_due.pop_front();
            if (want.value !== value || want.last !== last || want.ovf !== ovf) begin
               errors++;
               if (errors <= REPORT_MAX)
                  $display("mismatch: expected value %0d last %0b overflow %0b, got %0d %0b %0b",
                           want.value, want.last, want.ovf, value, last, ovf);
            end
         end
      endfunction

      function int pending();
         return sorted_due.size();
      endfunction
   endclass

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic signed [DATA_WIDTH-1:0] req_sample = '0;
   logic                         req_final_item = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic signed [DATA_WIDTH-1:0] rsp_sorted_value;
   logic                         rsp_final_result;
   logic                         rsp_overflow;

   batch_sort_board board = new(DEPTH);
   int              cycle_count = 0;
   int              burst_left = 0;
   int              sent_count = 0;
   int              stall_mode = 0;
   int              stall_left = 0;

   quicksort_engine #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample       (req_sample),
      .req_final_item   (req_final_item),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_final_result (rsp_final_result),
      .rsp_overflow     (rsp_overflow)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL quicksort_engine");
         $finish;
      end
   end

   // Receiver stall pattern: pick one of four ready modes at random and hold it until stall_left runs out.
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(16, 200);
      end
      stall_left--;
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= (cycle_count % 5 == 0);
         default: rsp_ready <= ($urandom_range(0, 15) != 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_sorted(rsp_sorted_value, rsp_final_result, rsp_overflow);
   end

   // Send one transaction; called right after a rising edge (or at start).
   task automatic send_item(input logic signed [DATA_WIDTH-1:0] value, input logic closing);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_sample     <= value;
      req_final_item <= closing;
      do
         @(posedge clock);
      while (!req_ready);
      board.take_sample(value, closing);
      sent_count++;
   endtask

   task automatic send_batch(input logic signed [DATA_WIDTH-1:0] values[$]);
      int i;
      for (i = 0; i < values.size(); i++)
         send_item(values[i], i == values.size() - 1);
   endtask

   // Hold off the sender until every queued result has come back.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (board.pending() != 0)
         @(posedge clock);
   endtask

   function automatic logic signed [DATA_WIDTH-1:0] make_value(fill_kind_type kind, int idx,
                                                               logic signed [DATA_WIDTH-1:0] base);
      logic signed [DATA_WIDTH-1:0] pick;
      case (kind)
         FILL_ASCENDING:  pick = base + idx;
         FILL_DESCENDING: pick = base - idx;
         FILL_EQUAL:      pick = base;
         FILL_NARROW:     pick = $signed($urandom_range(0, 7)) - 4;
         FILL_EXTREMES: begin
            case ($urandom_range(0, 4))
               0: pick = VAL_MAX;
               1: pick = VAL_MIN;
               2: pick = '0;
               3: pick = -1;
               default: pick = 1;
            endcase
         end
         default: pick = $urandom;
      endcase
      return pick;
   endfunction

   task automatic random_batch(input int size);
      logic signed [DATA_WIDTH-1:0] values[$];
      logic signed [DATA_WIDTH-1:0] base;
      fill_kind_type                kind;
      int                           i;
      kind = fill_kind_type'($urandom_range(0, 5));
      base = $urandom;
      for (i = 0; i < size; i++)
         values.push_back(make_value(kind, i, base));
      send_batch(values);
   endtask

   initial begin
      int size;
      int pick;
      int batch_no;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: single-value batches, extremes, duplicates, presorted and reversed input.
      send_batch('{VAL_MAX});
      send_batch('{VAL_MIN});
      drain_results();
      send_batch('{VAL_MAX, VAL_MIN});
      send_batch('{0, -1, 1});
      send_batch('{7, 7, 7, 7});
      send_batch('{VAL_MAX, 100, 0, -1, -100, VAL_MIN + 1, VAL_MIN});
      send_batch('{VAL_MIN, -5, 0, 5, VAL_MAX});
      drain_results();

      // Random: a full batch and an overflowing one first, then mostly small batches.
      batch_no = 0;
      while (sent_count < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (batch_no == 0 || (batch_no > 1 && pick >= 90 && pick < 96))
            size = DEPTH;
         else if (batch_no == 1 || pick >= 96)
            size = $urandom_range(DEPTH + 1, DEPTH + 8);
         else if (pick < 70)
            size = $urandom_range(1, 12);
         else
            size = $urandom_range(13, 40);
         random_batch(size);
         if (batch_no == 0 || $urandom_range(0, 3) == 0)
            drain_results();
         batch_no++;
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (board.pending() != 0)
         @(posedge clock);
      repeat (100) @(posedge clock);

      if (board.errors == 0)
         $display("PASS quicksort_engine");
      else
         $display("FAIL quicksort_engine");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/qse_pkg.sv
hdl/qse_ram.sv
hdl/quicksort_engine.sv
tb/tb_top.sv
